@@ src/stride_scheduler_ready_queue_top_assert.svh @@
// Assertion helpers for the ready queue.
`ifndef STRIDE_SCHEDULER_READY_QUEUE_TOP_ASSERT_SVH
`define STRIDE_SCHEDULER_READY_QUEUE_TOP_ASSERT_SVH

// Checked on every clock edge, skipped while in reset.
`define SRQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define SRQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ src/srq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srq_pkg
// Types and constants shared by the stride scheduler ready queue.
// ----------------------------------------------------------------------------
package srq_pkg;

  localparam int unsigned NUM_PROCS = 64;
  localparam int unsigned RING_AW   = $clog2(NUM_PROCS);
  localparam int unsigned PID_COUNT = 64;
  localparam int unsigned PID_W     = 6;
  localparam int unsigned PRIO_W    = 16;
  localparam int unsigned STRIDE_W  = 64;
  localparam int unsigned QUOT_W    = 32;
  localparam int unsigned DIV_CW    = 6;
  localparam logic [DIV_CW-1:0] DIV_LAST_BIT = DIV_CW'(32);

  localparam logic [1:0] FUNC_PUSH     = 2'd0;
  localparam logic [1:0] FUNC_POP_FIFO = 2'd1;
  localparam logic [1:0] FUNC_POP_STR  = 2'd2;

  localparam logic [PRIO_W-1:0] PRIO_MIN = PRIO_W'(2);

  typedef struct packed {
    logic [1:0]        func;
    logic [PID_W-1:0]  pid;
    logic [PRIO_W-1:0] prio;
    logic              new_process;
  } req_t;

  typedef struct packed {
    logic [PID_W-1:0] out_pid;
    logic             found;
    logic             overflow;
  } rsp_t;

  function automatic logic [RING_AW-1:0] ring_next(input logic [RING_AW-1:0] i);
    logic [RING_AW-1:0] n;
    if (i == RING_AW'(NUM_PROCS - 1)) begin
      n = '0;
    end else begin
      n = i + RING_AW'(1);
    end
    return n;
  endfunction

endpackage

@@ src/stride_scheduler_ready_queue_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stride_scheduler_ready_queue_top
// Ready queue of a stride scheduler: ring of process ids plus stride and
// priority tables, all held in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   A request (req_i) is taken on a clock edge with start_i high and busy_o
//   low. Exactly one response follows on rsp_o, marked by a one-cycle done_o.
//   The receiver cannot stall; the response must be captured when done_o is
//   high.
// Response path, request to done_o:
//   push, unused code, pop of an empty ring: answered from the idle state.
//   arrival-order pop: ring RAM read, then response.
//   stride pop over n queued ids: the scan reads ring RAM then stride RAM
//   for each entry; a bit-serial divider then produces 2^32 / priority.
// A new request is taken in the cycle done_o is high.
// Reset: ring empty, pointers zero, all strides zero (per-id valid bits);
//   no clearing pass is needed.
// ----------------------------------------------------------------------------
module stride_scheduler_ready_queue_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  srq_pkg::req_t req_i,
  output logic          busy_o,
  output logic          done_o,
  output srq_pkg::rsp_t rsp_o
);
  import srq_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FIFO  = 3'd1;
  localparam logic [2:0] S_SCANA = 3'd2;
  localparam logic [2:0] S_SCANB = 3'd3;
  localparam logic [2:0] S_PRIO  = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0]          state_q, state_d;
  logic [RING_AW-1:0]  head_q, head_d, tail_q, tail_d;
  logic                empty_q, empty_d;
  logic [RING_AW-1:0]  idx_q, idx_d, best_q, best_d, rem_q, rem_d;
  logic [PID_W-1:0]    best_id_q, best_id_d, head_id_q, head_id_d, cur_id_q, cur_id_d;
  logic [STRIDE_W-1:0] best_val_q, best_val_d;
  logic                first_q, first_d;
  logic [PRIO_W-1:0]   prio_q, prio_d, div_rem_q, div_rem_d;
  logic [QUOT_W-1:0]   quot_q, quot_d;
  logic [DIV_CW-1:0]   div_cnt_q, div_cnt_d;
  logic [PID_COUNT-1:0] vld_q, vld_d;
  rsp_t                rsp_q, rsp_d;
  logic                done_q, done_d;

  logic               ring_we;
  logic [RING_AW-1:0] ring_waddr, ring_raddr;
  logic [PID_W-1:0]   ring_wdata, ring_rdata;
  logic               str_we;
  logic [PID_W-1:0]   str_waddr, str_raddr;
  logic [STRIDE_W-1:0] str_wdata, str_rdata;
  logic               pri_we;
  logic [PID_W-1:0]   pri_waddr, pri_raddr;
  logic [PRIO_W-1:0]  pri_wdata, pri_rdata;

  logic [STRIDE_W-1:0] cur_val;
  logic [PRIO_W:0]     div_shift;
  logic                div_ge;
  logic [RING_AW:0]    occ;

  srq_ram #(.WIDTH(PID_W), .DEPTH(NUM_PROCS)) u_ring (
    .clk_i, .we_i(ring_we), .waddr_i(ring_waddr), .wdata_i(ring_wdata),
    .raddr_i(ring_raddr), .rdata_o(ring_rdata)
  );
  srq_ram #(.WIDTH(STRIDE_W), .DEPTH(PID_COUNT)) u_stride (
    .clk_i, .we_i(str_we), .waddr_i(str_waddr), .wdata_i(str_wdata),
    .raddr_i(str_raddr), .rdata_o(str_rdata)
  );
  srq_ram #(.WIDTH(PRIO_W), .DEPTH(PID_COUNT)) u_prio (
    .clk_i, .we_i(pri_we), .waddr_i(pri_waddr), .wdata_i(pri_wdata),
    .raddr_i(pri_raddr), .rdata_o(pri_rdata)
  );

  assign cur_val   = vld_q[cur_id_q] ? str_rdata : '0;
  assign div_shift = {div_rem_q, (div_cnt_q == DIV_LAST_BIT)};
  assign div_ge    = div_shift >= {1'b0, prio_q};
  assign occ       = (tail_q >= head_q) ? ({1'b0, tail_q} - {1'b0, head_q})
                   : ({1'b0, tail_q} + (RING_AW+1)'(NUM_PROCS) - {1'b0, head_q});

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    tail_d     = tail_q;
    empty_d    = empty_q;
    idx_d      = idx_q;
    best_d     = best_q;
    rem_d      = rem_q;
    best_id_d  = best_id_q;
    head_id_d  = head_id_q;
    cur_id_d   = cur_id_q;
    best_val_d = best_val_q;
    first_d    = first_q;
    prio_d     = prio_q;
    div_rem_d  = div_rem_q;
    quot_d     = quot_q;
    div_cnt_d  = div_cnt_q;
    vld_d      = vld_q;
    rsp_d      = '0;
    done_d     = 1'b0;
    ring_we    = 1'b0;
    ring_waddr = tail_q;
    ring_wdata = req_i.pid;
    ring_raddr = head_q;
    str_we     = 1'b0;
    str_waddr  = best_id_q;
    str_wdata  = best_val_q + STRIDE_W'(quot_q);
    str_raddr  = ring_rdata;
    pri_we     = 1'b0;
    pri_waddr  = req_i.pid;
    pri_wdata  = req_i.prio;
    pri_raddr  = best_id_q;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          unique case (req_i.func)
            FUNC_PUSH: begin
              done_d = 1'b1;
              if (!empty_q && head_q == tail_q) begin
                rsp_d.overflow = 1'b1;
              end else begin
                ring_we = 1'b1;
                pri_we  = 1'b1;
                if (req_i.new_process) begin
                  vld_d[req_i.pid] = 1'b0;
                end
                tail_d  = ring_next(tail_q);
                empty_d = 1'b0;
              end
            end
            FUNC_POP_FIFO: begin
              if (empty_q) begin
                done_d = 1'b1;
              end else begin
                state_d = S_FIFO;
              end
            end
            FUNC_POP_STR: begin
              if (empty_q) begin
                done_d = 1'b1;
              end else begin
                state_d = S_SCANA;
                idx_d   = head_q;
                first_d = 1'b1;
                rem_d   = (occ == '0) ? RING_AW'(NUM_PROCS - 1) : RING_AW'(occ - 1'b1);
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_FIFO: begin
        rsp_d.out_pid = ring_rdata;
        rsp_d.found   = 1'b1;
        done_d        = 1'b1;
        head_d        = ring_next(head_q);
        empty_d       = (ring_next(head_q) == tail_q);
        state_d       = S_IDLE;
      end
      S_SCANA: begin
        cur_id_d = ring_rdata;
        if (first_q) begin
          head_id_d = ring_rdata;
        end
        state_d = S_SCANB;
      end
      S_SCANB: begin
        first_d = 1'b0;
        if (first_q || cur_val < best_val_q) begin
          best_d     = idx_q;
          best_id_d  = cur_id_q;
          best_val_d = cur_val;
        end
        pri_raddr = best_id_d;
        if (rem_q == '0) begin
          state_d = S_PRIO;
        end else begin
          rem_d      = rem_q - RING_AW'(1);
          idx_d      = ring_next(idx_q);
          ring_raddr = ring_next(idx_q);
          state_d    = S_SCANA;
        end
      end
      S_PRIO: begin
        if (pri_rdata <= PRIO_W'(1)) begin
          prio_d    = PRIO_MIN;
          pri_we    = 1'b1;
          pri_waddr = best_id_q;
          pri_wdata = PRIO_MIN;
        end else begin
          prio_d = pri_rdata;
        end
        div_rem_d = '0;
        quot_d    = '0;
        div_cnt_d = DIV_LAST_BIT;
        state_d   = S_DIV;
      end
      S_DIV: begin
        div_rem_d = div_ge ? PRIO_W'(div_shift - {1'b0, prio_q}) : PRIO_W'(div_shift);
        quot_d    = {quot_q[QUOT_W-2:0], div_ge};
        div_cnt_d = div_cnt_q - DIV_CW'(1);
        if (div_cnt_q == '0) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        str_we           = 1'b1;
        vld_d[best_id_q] = 1'b1;
        ring_we          = 1'b1;
        ring_waddr       = best_q;
        ring_wdata       = head_id_q;
        rsp_d.out_pid    = best_id_q;
        rsp_d.found      = 1'b1;
        done_d           = 1'b1;
        head_d           = ring_next(head_q);
        empty_d          = (ring_next(head_q) == tail_q);
        state_d          = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      empty_q <= 1'b1;
      vld_q   <= '0;
      done_q  <= 1'b0;
      rsp_q   <= '0;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      empty_q <= empty_d;
      vld_q   <= vld_d;
      done_q  <= done_d;
      rsp_q   <= rsp_d;
      first_q <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    best_q     <= best_d;
    rem_q      <= rem_d;
    best_id_q  <= best_id_d;
    head_id_q  <= head_id_d;
    cur_id_q   <= cur_id_d;
    best_val_q <= best_val_d;
    prio_q     <= prio_d;
    div_rem_q  <= div_rem_d;
    quot_q     <= quot_d;
    div_cnt_q  <= div_cnt_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`include "stride_scheduler_ready_queue_top_assert.svh"

  `SRQ_ASSERT(a_req_answered, start_i && !busy_o |=> busy_o || done_o, "request not answered")
  `SRQ_ASSERT(a_rsp_excl, done_o |-> !(rsp_o.found && rsp_o.overflow), "found with overflow")
  `SRQ_ASSERT(a_empty_ptrs, empty_q |-> head_q == tail_q, "empty ring with unequal pointers")
  `SRQ_ASSERT_ALWAYS(a_idle_done, done_o |-> !busy_o, "response while busy")

endmodule

@@ src/srq_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srq_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module srq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ verif/stride_scheduler_ready_queue_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stride_scheduler_ready_queue_top_tb
// Drives push, arrival-order pop, lowest-stride pop and unused-code requests
// into the ready queue, predicts each response from a local copy of ring and
// tables, and checks every response field against the prediction.
// ----------------------------------------------------------------------------
module stride_scheduler_ready_queue_top_tb;
  import srq_pkg::*;

  localparam int unsigned WDOG_LIMIT = 20000;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct {
    req_t req;
    logic chk;
    rsp_t rsp;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  req_t req_i = '0;
  logic busy_o, done_o;
  rsp_t rsp_o;

  logic [PID_W-1:0]    q_ids [NUM_PROCS];
  logic [RING_AW-1:0]  q_head, q_tail;
  logic                q_empty;
  logic [STRIDE_W-1:0] q_stride [PID_COUNT];
  logic [PRIO_W-1:0]   q_prio [PID_COUNT];
  rsp_t                pending_rsp [$];
  int unsigned         n_fail = 0;
  int unsigned         idle_cnt = 0;
  bit                  hold_off = 1'b0;

  stride_scheduler_ready_queue_top dut (
    .clk_i, .rst_ni, .start_i, .req_i, .busy_o, .done_o, .rsp_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic rsp_t queue_step(input req_t r);
    rsp_t o;
    int unsigned cnt;
    logic [RING_AW-1:0] best, idx;
    logic [PID_W-1:0] sel;
    o = '0;
    case (r.func)
      FUNC_PUSH: begin
        if (!q_empty && q_head == q_tail) begin
          o.overflow = 1'b1;
        end else begin
          q_ids[q_tail] = r.pid;
          q_prio[r.pid] = r.prio;
          if (r.new_process) q_stride[r.pid] = '0;
          q_tail = ring_next(q_tail);
          q_empty = 1'b0;
        end
      end
      FUNC_POP_FIFO: begin
        if (!q_empty) begin
          o.out_pid = q_ids[q_head];
          o.found = 1'b1;
          q_head = ring_next(q_head);
          if (q_head == q_tail) q_empty = 1'b1;
        end
      end
      FUNC_POP_STR: begin
        if (!q_empty) begin
          cnt = (q_tail - q_head) % NUM_PROCS;
          if (cnt == 0) cnt = NUM_PROCS;
          best = q_head;
          idx = q_head;
          for (int k = 1; k < cnt; k++) begin
            idx = ring_next(idx);
            if (q_stride[q_ids[best]] > q_stride[q_ids[idx]]) best = idx;
          end
          sel = q_ids[best];
          if (q_prio[sel] <= 1) q_prio[sel] = PRIO_MIN;
          q_stride[sel] = q_stride[sel] + (64'd1 << 32) / 64'(q_prio[sel]);
          q_ids[best] = q_ids[q_head];
          o.out_pid = sel;
          o.found = 1'b1;
          q_head = ring_next(q_head);
          if (q_head == q_tail) q_empty = 1'b1;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni && done_o) begin
      if (pending_rsp.size() == 0) begin
        $error("response with nothing pending");
        n_fail++;
      end else begin
        e = pending_rsp.pop_front();
        if (rsp_o.out_pid !== e.out_pid) begin
          $error("out_pid exp %0d got %0d", e.out_pid, rsp_o.out_pid);
          n_fail++;
        end
        if (rsp_o.found !== e.found) begin
          $error("found exp %0d got %0d", e.found, rsp_o.found);
          n_fail++;
        end
        if (rsp_o.overflow !== e.overflow) begin
          $error("overflow exp %0d got %0d", e.overflow, rsp_o.overflow);
          n_fail++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (idle_cnt > WDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Drive one request; holds start_i until accepted. Leaves start_i high.
  task automatic send_req(input req_t r, input logic chk, input rsp_t exp_rsp,
                          input bit may_idle);
    rsp_t p;
    if (may_idle) begin
      while ($urandom_range(99) < 30) begin
        start_i <= 1'b0;
        req_i <= req_t'($urandom);
        @(posedge clk_i);
      end
    end
    start_i <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    p = queue_step(r);
    if (chk && p != exp_rsp) begin
      $error("table row out of step with prediction");
      n_fail++;
    end
    pending_rsp.push_back(p);
  endtask

  function automatic req_t mk(input logic [1:0] f, input logic [PID_W-1:0] id,
                              input logic [PRIO_W-1:0] pr, input logic np);
    req_t r;
    r.func = f;
    r.pid = id;
    r.prio = pr;
    r.new_process = np;
    return r;
  endfunction

  function automatic rsp_t mr(input logic [PID_W-1:0] id, input logic fd,
                              input logic ov);
    rsp_t r;
    r.out_pid = id;
    r.found = fd;
    r.overflow = ov;
    return r;
  endfunction

  initial begin
    row_t dir [$];
    req_t r;
    int unsigned depth, sel;
    for (int i = 0; i < NUM_PROCS; i++) q_ids[i] = '0;
    for (int i = 0; i < PID_COUNT; i++) begin
      q_stride[i] = '0;
      q_prio[i] = '0;
    end
    q_head = '0;
    q_tail = '0;
    q_empty = 1'b1;

    dir.push_back('{mk(FUNC_POP_FIFO, 6'd5, 16'd0, 1'b0), 1'b1, mr(6'd0, 1'b0, 1'b0)});
    dir.push_back('{mk(FUNC_POP_STR, 6'd9, 16'd0, 1'b0), 1'b1, mr(6'd0, 1'b0, 1'b0)});
    dir.push_back('{mk(FUNC_UNUSED, 6'd63, 16'hffff, 1'b1), 1'b1, mr(6'd0, 1'b0, 1'b0)});
    dir.push_back('{mk(FUNC_PUSH, 6'd63, 16'hffff, 1'b1), 1'b1, mr(6'd0, 1'b0, 1'b0)});
    dir.push_back('{mk(FUNC_PUSH, 6'd0, 16'd0, 1'b1), 1'b1, mr(6'd0, 1'b0, 1'b0)});
    dir.push_back('{mk(FUNC_PUSH, 6'd1, 16'd1, 1'b1), 1'b1, mr(6'd0, 1'b0, 1'b0)});
    dir.push_back('{mk(FUNC_PUSH, 6'd2, 16'd2, 1'b0), 1'b1, mr(6'd0, 1'b0, 1'b0)});
    dir.push_back('{mk(FUNC_POP_STR, 6'd0, 16'd0, 1'b0), 1'b1, mr(6'd63, 1'b1, 1'b0)});
    dir.push_back('{mk(FUNC_POP_STR, 6'd0, 16'd0, 1'b0), 1'b0, '0});
    dir.push_back('{mk(FUNC_POP_STR, 6'd0, 16'd0, 1'b0), 1'b0, '0});
    dir.push_back('{mk(FUNC_POP_FIFO, 6'd0, 16'd0, 1'b0), 1'b0, '0});
    dir.push_back('{mk(FUNC_POP_FIFO, 6'd0, 16'd0, 1'b0), 1'b1, mr(6'd0, 1'b0, 1'b0)});

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir[i]) send_req(dir[i].req, dir[i].chk, dir[i].rsp, 1'b1);
    // fill to full, overflow, then drain with stride pops
    for (int i = 0; i < NUM_PROCS + 2; i++) begin
      r = mk(FUNC_PUSH, PID_W'(i), PRIO_W'($urandom_range(3)), 1'($urandom));
      send_req(r, 1'b0, '0, 1'b0);
    end
    for (int i = 0; i < NUM_PROCS + 1; i++)
      send_req(mk(FUNC_POP_STR, 6'd0, 16'd0, 1'b0), 1'b0, '0, 1'b0);

    start_i <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);

    depth = 0;
    for (int n = 0; n < 2000; n++) begin
      sel = $urandom_range(99);
      r = req_t'($urandom);
      if (sel < 40 + (depth < 8 ? 20 : 0)) r.func = FUNC_PUSH;
      else if (sel < 60) r.func = FUNC_POP_FIFO;
      else if (sel < 97) r.func = FUNC_POP_STR;
      else r.func = FUNC_UNUSED;
      if ($urandom_range(3) == 0) r.pid = PID_W'($urandom_range(3));
      if ($urandom_range(3) == 0) r.prio = PRIO_W'($urandom_range(3));
      send_req(r, 1'b0, '0, n > 1000 || n < 700);
      depth = (q_tail - q_head) % NUM_PROCS;
      if (!q_empty && depth == 0) depth = NUM_PROCS;
    end
    start_i <= 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
